### rtl/fourth_order_stencil_derivative_defines.svh
// ---------------------------------------------------------------------------
// Stencil derivative assertion macros
// Concurrent checks sampled on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef FOURTH_ORDER_STENCIL_DERIVATIVE_DEFINES_SVH
`define FOURTH_ORDER_STENCIL_DERIVATIVE_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define FOSD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stencil derivative check failed");

// The consequent holds in the cycle after the antecedent.
`define FOSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stencil derivative check failed");

`endif

### rtl/fosd_pkg.sv
// ---------------------------------------------------------------------------
// fosd_pkg
// Shared constants, stencil table and types of the stencil derivative block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fosd_pkg;

  localparam int SAMPLE_W = 32;
  localparam int INV_W    = 32;
  localparam int INV_FRAC = 16;
  localparam int TAPS     = 5;
  localparam int ROW_W    = 3;
  localparam int CNT_W    = 3;
  localparam int COEF_W   = 8;

  localparam int SUM_W = SAMPLE_W + 8;
  localparam int MAG_W = SAMPLE_W + 7;
  localparam int LO_W  = 32;
  localparam int HI_W  = MAG_W - LO_W;
  localparam int PLO_W = LO_W + INV_W;
  localparam int PHI_W = HI_W + INV_W;
  localparam int RES_W = PHI_W + LO_W - INV_FRAC + 1;

  localparam logic [INV_W-1:0] INV_RESET = INV_W'(65536);

  localparam int JQ_DEPTH = 4;
  localparam int JQ_PTR_W = $clog2(JQ_DEPTH);
  localparam int JQ_CNT_W = $clog2(JQ_DEPTH + 1);

  localparam int OQ_DEPTH = 8;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);
  localparam int FLY_W    = 2;

  localparam logic [ROW_W-1:0] ROW_FIRST  = ROW_W'(0);
  localparam logic [ROW_W-1:0] ROW_SECOND = ROW_W'(1);
  localparam logic [ROW_W-1:0] ROW_CENTER = ROW_W'(2);
  localparam logic [ROW_W-1:0] ROW_PENULT = ROW_W'(3);
  localparam logic [ROW_W-1:0] ROW_END    = ROW_W'(4);

  localparam logic [CNT_W-1:0] NUM_ONE   = CNT_W'(1);
  localparam logic [CNT_W-1:0] NUM_THREE = CNT_W'(3);
  localparam logic [CNT_W-1:0] NUM_FIVE  = CNT_W'(5);

  localparam logic [CNT_W-1:0] SEEN_HEAD = CNT_W'(4);
  localparam logic [CNT_W-1:0] SEEN_MAX  = CNT_W'(5);

  // Rows: first point, second point, central, next-to-last, last.
  localparam logic signed [COEF_W-1:0] STENCIL [TAPS][TAPS] = '{
    '{-8'sd25,  8'sd48, -8'sd36,  8'sd16, -8'sd3 },
    '{-8'sd3,  -8'sd10,  8'sd18, -8'sd6,   8'sd1 },
    '{ 8'sd1,  -8'sd8,   8'sd0,   8'sd8,  -8'sd1 },
    '{-8'sd1,   8'sd6,  -8'sd18,  8'sd10,  8'sd3 },
    '{ 8'sd3,  -8'sd16,  8'sd36, -8'sd48,  8'sd25}
  };

  typedef struct packed {
    logic [TAPS-1:0][SAMPLE_W-1:0] win;
    logic [ROW_W-1:0]              first_row;
    logic [CNT_W-1:0]              num;
    logic                          zero;
    logic                          last;
  } job_t;

  typedef struct packed {
    logic [OQ_CNT_W-1:0] occ;
    logic [FLY_W-1:0]    inflight;
  } back_stat_t;

endpackage

`default_nettype wire

### rtl/fourth_order_stencil_derivative.sv
// ---------------------------------------------------------------------------
// fourth_order_stencil_derivative
// Fourth-order finite-difference derivative of a stream of grid samples.
// ---------------------------------------------------------------------------
// Samples enter as words on the in_ channel (push/full) with in_is_last on
// the final sample of a sequence. Derivative words leave on the out_ channel
// (empty/pop), in grid order, with out_last_out on the final point.
// The cfg_ channel writes the scale 1/(12h); cfg_ready is always high and a
// write is expected only while the block is idle.
// Each input word yields zero to five result words. The back end gives one
// result per cycle through a four-stage pipeline while the result queue has
// room, so long sequences stream at one word per cycle; the extra results at
// the start and end of a sequence are absorbed by the four-entry job queue.
// When the receiver stops popping, the eight-entry result queue fills, the
// back end holds, the job queue fills and in_full rises; nothing is lost.
// Reset clears both queues and the sequence count and sets the scale to 1.0.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "fourth_order_stencil_derivative_defines.svh"

module fourth_order_stencil_derivative (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic signed [fosd_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                 in_is_last,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output logic signed [fosd_pkg::SAMPLE_W-1:0] out_derivative,
  output logic                                 out_last_out,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [fosd_pkg::INV_W-1:0]           cfg_data
);

  logic [fosd_pkg::INV_W-1:0] inv_r;
  logic                       jq_full;
  logic                       job_push;
  fosd_pkg::job_t             push_job;
  logic                       job_valid;
  logic                       job_pop;
  fosd_pkg::job_t             head_job;
  fosd_pkg::back_stat_t       bk_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= fosd_pkg::INV_RESET;
    end else if (cfg_valid && cfg_ready) begin
      inv_r <= cfg_data;
    end
  end

  fosd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_sample  (in_sample),
    .in_is_last (in_is_last),
    .jq_full    (jq_full),
    .job_push   (job_push),
    .job        (push_job)
  );

  fosd_jobq u_jobq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (job_push),
    .push_job   (push_job),
    .full       (jq_full),
    .pop        (job_pop),
    .head_valid (job_valid),
    .head_job   (head_job)
  );

  fosd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .job_valid      (job_valid),
    .job            (head_job),
    .job_pop        (job_pop),
    .inv_step       (inv_r),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_derivative (out_derivative),
    .out_last_out   (out_last_out),
    .stat           (bk_stat)
  );

  `FOSD_ASSERT_NEXT(a_cfg_write, cfg_valid && cfg_ready, inv_r == $past(cfg_data))
  `FOSD_ASSERT_SAME(a_oq_credit, 1'b1, (32'(bk_stat.occ) + 32'(bk_stat.inflight)) <= fosd_pkg::OQ_DEPTH)
  `FOSD_ASSERT_SAME(a_jq_no_drop, job_push, !jq_full)

endmodule

`default_nettype wire

### rtl/fosd_front.sv
// ---------------------------------------------------------------------------
// fosd_front
// Keeps the sample window and sequence count and turns words into jobs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fosd_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic signed [fosd_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                in_is_last,
  input  logic                                jq_full,
  output logic                                job_push,
  output fosd_pkg::job_t                      job
);

  logic [fosd_pkg::TAPS-1:0][fosd_pkg::SAMPLE_W-1:0] win_r;
  logic [fosd_pkg::TAPS-1:0][fosd_pkg::SAMPLE_W-1:0] win_nxt;
  logic [fosd_pkg::CNT_W-1:0]                        seen_r;
  logic [fosd_pkg::CNT_W-1:0]                        seen_nxt;
  logic                                              accept;

  assign in_full = jq_full;
  assign accept  = in_push && !jq_full;
  assign win_nxt = {in_sample, win_r[fosd_pkg::TAPS-1:1]};

  always_comb begin
    seen_nxt = seen_r;
    if (accept) begin
      if (in_is_last) begin
        seen_nxt = '0;
      end else if (seen_r < fosd_pkg::SEEN_MAX) begin
        seen_nxt = seen_r + fosd_pkg::CNT_W'(1);
      end
    end
  end

  always_comb begin
    job_push      = 1'b0;
    job.win       = win_nxt;
    job.first_row = fosd_pkg::ROW_FIRST;
    job.num       = fosd_pkg::NUM_ONE;
    job.zero      = 1'b0;
    job.last      = in_is_last;
    if (!in_is_last) begin
      if (seen_r == fosd_pkg::SEEN_HEAD) begin
        job_push = accept;
        job.num  = fosd_pkg::NUM_THREE;
      end else if (seen_r >= fosd_pkg::SEEN_MAX) begin
        job_push      = accept;
        job.first_row = fosd_pkg::ROW_CENTER;
      end
    end else begin
      job_push = accept;
      if (seen_r < fosd_pkg::SEEN_HEAD) begin
        job.zero = 1'b1;
        job.num  = seen_r + fosd_pkg::CNT_W'(1);
      end else if (seen_r == fosd_pkg::SEEN_HEAD) begin
        job.num = fosd_pkg::NUM_FIVE;
      end else begin
        job.first_row = fosd_pkg::ROW_CENTER;
        job.num       = fosd_pkg::NUM_THREE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else begin
      seen_r <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win_r <= win_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/fosd_jobq.sv
// ---------------------------------------------------------------------------
// fosd_jobq
// Short job queue that decouples the front from the arithmetic back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fosd_jobq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  fosd_pkg::job_t                push_job,
  output logic                          full,
  input  logic                          pop,
  output logic                          head_valid,
  output fosd_pkg::job_t                head_job
);

  fosd_pkg::job_t                  mem_r [fosd_pkg::JQ_DEPTH];
  logic [fosd_pkg::JQ_PTR_W-1:0]   wr_ptr_r;
  logic [fosd_pkg::JQ_PTR_W-1:0]   rd_ptr_r;
  logic [fosd_pkg::JQ_CNT_W-1:0]   cnt_r;
  logic [fosd_pkg::JQ_CNT_W-1:0]   cnt_nxt;
  logic                            do_push;
  logic                            do_pop;

  assign full       = (cnt_r == fosd_pkg::JQ_CNT_W'(fosd_pkg::JQ_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + fosd_pkg::JQ_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - fosd_pkg::JQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + fosd_pkg::JQ_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + fosd_pkg::JQ_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

### rtl/fosd_back.sv
// ---------------------------------------------------------------------------
// fosd_back
// Steps through the rows of each job, computes stencil sums, scales,
// rounds and saturates them, and queues the results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fosd_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 job_valid,
  input  fosd_pkg::job_t                       job,
  output logic                                 job_pop,
  input  logic [fosd_pkg::INV_W-1:0]           inv_step,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output logic signed [fosd_pkg::SAMPLE_W-1:0] out_derivative,
  output logic                                 out_last_out,
  output fosd_pkg::back_stat_t                 stat
);

  localparam int SW = fosd_pkg::SAMPLE_W;
  localparam logic [fosd_pkg::RES_W-1:0] POS_MAX =
    {{(fosd_pkg::RES_W - SW + 1){1'b0}}, {(SW - 1){1'b1}}};
  localparam logic [fosd_pkg::RES_W-1:0] NEG_LIM =
    {{(fosd_pkg::RES_W - SW){1'b0}}, 1'b1, {(SW - 1){1'b0}}};
  localparam logic [SW-1:0] SAT_POS = {1'b0, {(SW - 1){1'b1}}};
  localparam logic [SW-1:0] SAT_NEG = {1'b1, {(SW - 1){1'b0}}};
  localparam logic [fosd_pkg::PLO_W:0] ROUND_HALF =
    (fosd_pkg::PLO_W + 1)'(1) << (fosd_pkg::INV_FRAC - 1);

  typedef struct packed {
    logic [SW-1:0] deriv;
    logic          last;
  } res_t;

  // Row sequencer.
  logic [fosd_pkg::CNT_W-1:0] step_r;
  logic [fosd_pkg::CNT_W-1:0] step_nxt;
  logic [fosd_pkg::ROW_W-1:0] row;
  logic                       last_step;
  logic                       credit_ok;
  logic                       issue;

  // Stage 1: tap products.
  logic                                   s1_v_r;
  logic                                   s1_last_r;
  logic signed [fosd_pkg::SUM_W-1:0]      s1_prod_r   [fosd_pkg::TAPS];
  logic signed [fosd_pkg::SUM_W-1:0]      s1_prod_nxt [fosd_pkg::TAPS];

  // Stage 2: stencil sum.
  logic                                   s2_v_r;
  logic                                   s2_last_r;
  logic signed [fosd_pkg::SUM_W-1:0]      s2_sum_r;
  logic signed [fosd_pkg::SUM_W-1:0]      s2_sum_nxt;

  // Stage 3: scaling products.
  logic                                   s3_v_r;
  logic                                   s3_last_r;
  logic                                   s3_neg_r;
  logic [fosd_pkg::PLO_W-1:0]             s3_plo_r;
  logic [fosd_pkg::PHI_W-1:0]             s3_phi_r;
  logic [fosd_pkg::SUM_W-1:0]             mag_full;
  logic [fosd_pkg::MAG_W-1:0]             mag;

  // Round, saturate and result queue.
  logic [fosd_pkg::PLO_W:0]               rnd;
  logic [fosd_pkg::RES_W-1:0]             r_val;
  logic [fosd_pkg::RES_W-1:0]             r_neg;
  res_t                                   res;
  res_t                                   oq_mem_r [fosd_pkg::OQ_DEPTH];
  logic [fosd_pkg::OQ_PTR_W-1:0]          oq_wr_r;
  logic [fosd_pkg::OQ_PTR_W-1:0]          oq_rd_r;
  logic [fosd_pkg::OQ_CNT_W-1:0]          occ_r;
  logic [fosd_pkg::OQ_CNT_W-1:0]          occ_nxt;
  logic [fosd_pkg::FLY_W-1:0]             inflight;
  logic                                   oq_pop;

  assign inflight  = fosd_pkg::FLY_W'(s1_v_r) + fosd_pkg::FLY_W'(s2_v_r)
                   + fosd_pkg::FLY_W'(s3_v_r);
  assign credit_ok = ((fosd_pkg::OQ_CNT_W + 1)'(occ_r) + (fosd_pkg::OQ_CNT_W + 1)'(inflight))
                     < (fosd_pkg::OQ_CNT_W + 1)'(fosd_pkg::OQ_DEPTH);
  assign issue     = job_valid && credit_ok;
  assign row       = job.first_row + fosd_pkg::ROW_W'(step_r);
  assign last_step = ((step_r + fosd_pkg::CNT_W'(1)) == job.num);
  assign job_pop   = issue && last_step;

  always_comb begin
    step_nxt = step_r;
    if (issue) begin
      step_nxt = last_step ? '0 : step_r + fosd_pkg::CNT_W'(1);
    end
  end

  always_comb begin
    for (int i = 0; i < fosd_pkg::TAPS; i++) begin
      s1_prod_nxt[i] = job.zero ? '0 :
        fosd_pkg::SUM_W'($signed(job.win[i])) *
        fosd_pkg::SUM_W'(fosd_pkg::STENCIL[row][i]);
    end
  end

  always_comb begin
    s2_sum_nxt = '0;
    for (int i = 0; i < fosd_pkg::TAPS; i++) begin
      s2_sum_nxt = s2_sum_nxt + s1_prod_r[i];
    end
  end

  assign mag_full = s2_sum_r[fosd_pkg::SUM_W-1] ? -s2_sum_r : s2_sum_r;
  assign mag      = mag_full[fosd_pkg::MAG_W-1:0];

  always_comb begin
    rnd   = (fosd_pkg::PLO_W + 1)'(s3_plo_r) + ROUND_HALF;
    r_val = fosd_pkg::RES_W'({s3_phi_r, {(fosd_pkg::LO_W - fosd_pkg::INV_FRAC){1'b0}}})
          + fosd_pkg::RES_W'(rnd >> fosd_pkg::INV_FRAC);
    r_neg = -r_val;
    res.last = s3_last_r;
    if (!s3_neg_r) begin
      res.deriv = (r_val > POS_MAX) ? SAT_POS : r_val[SW-1:0];
    end else begin
      res.deriv = (r_val > NEG_LIM) ? SAT_NEG : r_neg[SW-1:0];
    end
  end

  assign oq_pop         = out_pop && (occ_r != '0);
  assign out_empty      = (occ_r == '0);
  assign out_derivative = $signed(oq_mem_r[oq_rd_r].deriv);
  assign out_last_out   = oq_mem_r[oq_rd_r].last;
  assign stat.occ       = occ_r;
  assign stat.inflight  = inflight;

  always_comb begin
    occ_nxt = occ_r;
    if (s3_v_r && !oq_pop) begin
      occ_nxt = occ_r + fosd_pkg::OQ_CNT_W'(1);
    end else if (oq_pop && !s3_v_r) begin
      occ_nxt = occ_r - fosd_pkg::OQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      oq_wr_r <= '0;
      oq_rd_r <= '0;
      occ_r   <= '0;
    end else begin
      step_r <= step_nxt;
      s1_v_r <= issue;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      occ_r  <= occ_nxt;
      if (s3_v_r) begin
        oq_wr_r <= oq_wr_r + fosd_pkg::OQ_PTR_W'(1);
      end
      if (oq_pop) begin
        oq_rd_r <= oq_rd_r + fosd_pkg::OQ_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_prod_r <= s1_prod_nxt;
    s1_last_r <= job.last && last_step;
    s2_sum_r  <= s2_sum_nxt;
    s2_last_r <= s1_last_r;
    s3_last_r <= s2_last_r;
    s3_neg_r  <= s2_sum_r[fosd_pkg::SUM_W-1];
    s3_plo_r  <= fosd_pkg::PLO_W'(mag[fosd_pkg::LO_W-1:0]) * fosd_pkg::PLO_W'(inv_step);
    s3_phi_r  <= fosd_pkg::PHI_W'(mag[fosd_pkg::MAG_W-1:fosd_pkg::LO_W])
               * fosd_pkg::PHI_W'(inv_step);
    if (s3_v_r) begin
      oq_mem_r[oq_wr_r] <= res;
    end
  end

endmodule

`default_nettype wire
